FILE: design/tsc_pkg.sv
`timescale 1ns / 1ps

package tsc_pkg;

    // Field widths of the stream words
    localparam int IN_W     = 32;
    localparam int HIST_W   = 48;
    localparam int RADIUS_W = 6;
    localparam int CHAN_N   = 3;
    localparam int TDATA_W  = CHAN_N * IN_W;

    // Default ring depth and register reset value
    localparam int HISTORY_DEPTH_DEF = 64;
    localparam logic [RADIUS_W-1:0] RADIUS_RESET = 6'd50;

    // Channel codes: x and angle
    localparam logic [1:0] CHAN_X     = 2'd0;
    localparam logic [1:0] CHAN_ANGLE = 2'd2;

    // Saturation limits of a 32-bit signed result
    localparam logic [IN_W-1:0] SAT_POS = 32'h7FFF_FFFF;
    localparam logic [IN_W-1:0] SAT_NEG = 32'h8000_0000;

endpackage

FILE: design/trajectory_smoothing_corrector_unit.sv
`timescale 1ns / 1ps
// Trajectory smoothing corrector.
// s_ channel: one word per frame, s_tdata = {angle, shift_y, shift_x}, each
//   32-bit signed. m_ channel: one word per input, m_tdata =
//   {corrected_angle, corrected_y, corrected_x}, each 32-bit signed, saturated.
// cfg channel: cfg_data writes window_radius (reset 50); cfg_ready is always
//   high. Write it only while the block is idle.
// Each frame is added to three 48-bit cumulative trajectories, the new point
//   is stored in a ring of HISTORY_DEPTH entries, and the newest
//   min(frames seen, radius+1) points are averaged.
// The sums are SUM_W = 48 + log2(HISTORY_DEPTH) bits wide. The ring is read
//   one entry a cycle and one shared one-bit-per-cycle divider serves the
//   three channels in turn.
// One frame is processed at a time; s_tready is high only in idle. The result
//   sits in an output register, so the next frame is accepted while it waits.
//   If the receiver stalls, a finished result waits until that register frees.
// Reset (aresetn low, synchronous) clears the trajectories, the frame count and
//   the ring pointer and restores the radius; the ring needs no clearing pass.

module trajectory_smoothing_corrector_unit #(
    parameter int HISTORY_DEPTH = tsc_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    // s_tdata: shift_x [31:0], shift_y [63:32], angle [95:64]
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [tsc_pkg::TDATA_W-1:0]   s_tdata,
    // m_tdata: corrected_x [31:0], corrected_y [63:32], corrected_angle [95:64]
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [tsc_pkg::TDATA_W-1:0]   m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [tsc_pkg::RADIUS_W-1:0]  cfg_data
);

    import tsc_pkg::*;

    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int COUNT_W = $clog2(HISTORY_DEPTH + 1);
    localparam int RAD1_W  = RADIUS_W + 1;
    localparam int CMP_W   = (COUNT_W > RAD1_W) ? COUNT_W : RAD1_W;
    localparam int SUM_W   = HIST_W + $clog2(HISTORY_DEPTH);
    localparam int RES_W   = SUM_W + 2;
    localparam int MEM_W   = CHAN_N * HIST_W;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WRITE,
        ST_SUM,
        ST_DIV_START,
        ST_DIV_WAIT,
        ST_CORR,
        ST_OUT
    } state_t;

    state_t                    state_reg;
    logic [RADIUS_W-1:0]       radius_reg;
    logic [COUNT_W-1:0]        points_seen_reg;
    logic [SLOT_W-1:0]         write_slot_reg;
    logic [SLOT_W-1:0]         rd_slot_reg;
    logic [COUNT_W-1:0]        count_reg;
    logic [COUNT_W-1:0]        issue_left_reg;
    logic                      rd_valid_reg;
    logic [1:0]                chan_reg;
    logic                      m_tvalid_reg;
    logic [TDATA_W-1:0]        m_tdata_reg;
    logic [HIST_W-1:0]         cum_reg [CHAN_N];

    logic [IN_W-1:0]           in_reg  [CHAN_N];
    logic signed [SUM_W-1:0]   sum_reg [CHAN_N];
    logic signed [SUM_W-1:0]   mean_reg;
    logic [IN_W-1:0]           res_reg [CHAN_N];

    logic [MEM_W-1:0]          mem [HISTORY_DEPTH];
    logic [MEM_W-1:0]          rd_data_reg;

    logic                      s_accept;
    logic                      rd_en;
    logic                      mem_we;
    logic                      load_out;
    logic [CMP_W-1:0]          rad_ext;
    logic [CMP_W-1:0]          seen_ext;
    logic [COUNT_W-1:0]        count_c;
    logic [SLOT_W-1:0]         slot_inc;
    logic [SLOT_W-1:0]         slot_dec;
    logic signed [RES_W-1:0]   corr;
    logic                      corr_fits;
    logic [IN_W-1:0]           corr_sat;
    logic                      div_start;
    logic                      div_done;
    logic signed [SUM_W-1:0]   div_quot;

    assign s_accept  = s_tvalid && s_tready;
    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    // Window size: radius + 1, capped by the points stored so far
    assign rad_ext  = CMP_W'({1'b0, radius_reg}) + CMP_W'(1);
    assign seen_ext = CMP_W'(points_seen_reg);
    assign count_c  = (rad_ext < seen_ext) ? rad_ext[COUNT_W-1:0] : points_seen_reg;

    // Ring pointer arithmetic with wrap at any depth
    assign slot_inc = (write_slot_reg == SLOT_W'(HISTORY_DEPTH - 1)) ? '0 : write_slot_reg + 1'b1;
    assign slot_dec = (rd_slot_reg == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : rd_slot_reg - 1'b1;

    assign mem_we    = (state_reg == ST_WRITE);
    assign rd_en     = (state_reg == ST_SUM) && (issue_left_reg != '0);
    assign div_start = (state_reg == ST_DIV_START);

    // Load the result once the output register is free
    assign load_out  = (state_reg == ST_OUT) && (!m_tvalid_reg || m_tready);

    // Correct one channel: input + mean - cumulative, then saturate
    assign corr = RES_W'($signed(in_reg[chan_reg])) + RES_W'(mean_reg)
                - RES_W'($signed(cum_reg[chan_reg]));
    assign corr_fits = (&corr[RES_W-1:IN_W-1]) || !(|corr[RES_W-1:IN_W-1]);
    assign corr_sat  = corr_fits ? corr[IN_W-1:0] : (corr[RES_W-1] ? SAT_NEG : SAT_POS);

    // Hold the window radius
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            radius_reg <= RADIUS_RESET;
        end else if (cfg_valid && cfg_ready) begin
            radius_reg <= cfg_data;
        end
    end

    // Ring memory: one write port, one registered read port
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[write_slot_reg] <= {cum_reg[2], cum_reg[1], cum_reg[0]};
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_slot_reg];
        end
    end

    // Sequencer, trajectories and output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            points_seen_reg <= '0;
            write_slot_reg  <= '0;
            issue_left_reg  <= '0;
            rd_valid_reg    <= 1'b0;
            chan_reg        <= CHAN_X;
            m_tvalid_reg    <= 1'b0;
            for (int i = 0; i < CHAN_N; i++) begin
                cum_reg[i] <= '0;
            end
        end else begin
            // Raise valid on a load, drop it once the word is taken
            if (load_out) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            rd_valid_reg <= rd_en;
            case (state_reg)
                ST_IDLE: begin
                    if (s_accept) begin
                        for (int i = 0; i < CHAN_N; i++) begin
                            cum_reg[i] <= cum_reg[i]
                                        + HIST_W'($signed(s_tdata[i*IN_W +: IN_W]));
                        end
                        if (points_seen_reg != COUNT_W'(HISTORY_DEPTH)) begin
                            points_seen_reg <= points_seen_reg + 1'b1;
                        end
                        state_reg <= ST_WRITE;
                    end
                end
                ST_WRITE: begin
                    count_reg      <= count_c;
                    issue_left_reg <= count_c;
                    rd_slot_reg    <= write_slot_reg;
                    write_slot_reg <= slot_inc;
                    state_reg      <= ST_SUM;
                end
                ST_SUM: begin
                    // Walk back from the newest point
                    if (rd_en) begin
                        rd_slot_reg    <= slot_dec;
                        issue_left_reg <= issue_left_reg - 1'b1;
                    end else if (!rd_valid_reg) begin
                        chan_reg  <= CHAN_X;
                        state_reg <= ST_DIV_START;
                    end
                end
                ST_DIV_START: begin
                    state_reg <= ST_DIV_WAIT;
                end
                ST_DIV_WAIT: begin
                    if (div_done) begin
                        state_reg <= ST_CORR;
                    end
                end
                ST_CORR: begin
                    if (chan_reg == CHAN_ANGLE) begin
                        state_reg <= ST_OUT;
                    end else begin
                        chan_reg  <= chan_reg + 1'b1;
                        state_reg <= ST_DIV_START;
                    end
                end
                ST_OUT: begin
                    if (load_out) begin
                        m_tdata_reg <= {res_reg[2], res_reg[1], res_reg[0]};
                        state_reg   <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_accept) begin
            for (int i = 0; i < CHAN_N; i++) begin
                in_reg[i] <= s_tdata[i*IN_W +: IN_W];
            end
        end
        if (state_reg == ST_WRITE) begin
            for (int i = 0; i < CHAN_N; i++) begin
                sum_reg[i] <= '0;
            end
        end else if (rd_valid_reg) begin
            for (int i = 0; i < CHAN_N; i++) begin
                sum_reg[i] <= sum_reg[i] + SUM_W'($signed(rd_data_reg[i*HIST_W +: HIST_W]));
            end
        end
        if (state_reg == ST_DIV_WAIT && div_done) begin
            mean_reg <= div_quot;
        end
        if (state_reg == ST_CORR) begin
            res_reg[chan_reg] <= corr_sat;
        end
    end

    tsc_divider #(
        .DIVIDEND_W (SUM_W),
        .DIVISOR_W  (COUNT_W)
    ) u_divider (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (div_start),
        .dividend (sum_reg[chan_reg]),
        .divisor  (count_reg),
        .done     (div_done),
        .quotient (div_quot)
    );

endmodule

FILE: design/tsc_divider.sv
`timescale 1ns / 1ps

module tsc_divider #(
    parameter int DIVIDEND_W = 54,
    parameter int DIVISOR_W  = 7
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         start,
    input  logic signed [DIVIDEND_W-1:0] dividend,
    input  logic        [DIVISOR_W-1:0]  divisor,
    output logic                         done,
    output logic signed [DIVIDEND_W-1:0] quotient
);

    localparam int STEP_W = $clog2(DIVIDEND_W + 1);

    typedef enum logic [1:0] {
        DV_IDLE,
        DV_RUN,
        DV_FIX
    } div_state_t;

    div_state_t                  state_reg;
    logic [STEP_W-1:0]           step_reg;
    logic                        neg_reg;
    logic [DIVIDEND_W-1:0]       q_reg;
    logic [DIVISOR_W-1:0]        rem_reg;
    logic [DIVISOR_W-1:0]        divisor_reg;
    logic                        done_reg;
    logic signed [DIVIDEND_W-1:0] quotient_reg;

    logic [DIVISOR_W:0]          trial;
    logic                        fits;
    logic [DIVISOR_W:0]          trial_diff;
    logic [DIVIDEND_W-1:0]       magnitude;

    // One restoring step: bring down the next dividend bit
    assign trial      = {rem_reg, q_reg[DIVIDEND_W-1]};
    assign fits       = trial >= {1'b0, divisor_reg};
    assign trial_diff = trial - {1'b0, divisor_reg};
    assign magnitude  = dividend[DIVIDEND_W-1] ? DIVIDEND_W'(-dividend) : DIVIDEND_W'(dividend);

    // Sequence the divide, one quotient bit per cycle
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= DV_IDLE;
            done_reg  <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            case (state_reg)
                DV_IDLE: begin
                    if (start) begin
                        neg_reg     <= dividend[DIVIDEND_W-1];
                        q_reg       <= magnitude;
                        rem_reg     <= '0;
                        divisor_reg <= divisor;
                        step_reg    <= STEP_W'(DIVIDEND_W);
                        state_reg   <= DV_RUN;
                    end
                end
                DV_RUN: begin
                    rem_reg  <= fits ? trial_diff[DIVISOR_W-1:0] : trial[DIVISOR_W-1:0];
                    q_reg    <= {q_reg[DIVIDEND_W-2:0], fits};
                    step_reg <= step_reg - 1'b1;
                    if (step_reg == STEP_W'(1)) begin
                        state_reg <= DV_FIX;
                    end
                end
                DV_FIX: begin
                    // Restore the sign: truncation toward zero
                    quotient_reg <= neg_reg ? -$signed(q_reg) : $signed(q_reg);
                    done_reg     <= 1'b1;
                    state_reg    <= DV_IDLE;
                end
                default: begin
                    state_reg <= DV_IDLE;
                end
            endcase
        end
    end

    assign done     = done_reg;
    assign quotient = quotient_reg;

endmodule

FILE: design/tsc_checker.sv
`timescale 1ns / 1ps

module tsc_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        s_tvalid,
    input logic                        s_tready,
    input logic                        m_tvalid,
    input logic                        m_tready,
    input logic [tsc_pkg::TDATA_W-1:0] m_tdata
);

    import tsc_pkg::*;

    // Reset empties the output register
    a_reset_clears_out: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("m_tvalid high after reset");

    // A frame in work blocks the next one
    a_busy_after_accept: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("s_tready high right after an accepted word");

    // A result never appears the cycle after its frame is taken
    a_no_instant_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result word appeared too early");

    // A stalled result word holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result word changed");

endmodule

bind trajectory_smoothing_corrector_unit tsc_checker u_tsc_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
